[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define GRFP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define GRFP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/grfp_pkg.sv]
// ----------------------------------------------------------------------------
// grfp_pkg
// Types and frame constants for the gimbal reply frame parser.
// ----------------------------------------------------------------------------
package grfp_pkg;

  // Angle frame
  localparam logic [7:0] AngleHdr0   = 8'h3E;
  localparam logic [7:0] AngleHdr1   = 8'h3D;
  localparam logic [7:0] AngleHdr2   = 8'h36;
  localparam logic [7:0] AngleHdr3   = 8'h73;
  localparam logic [5:0] PayloadLen  = 6'd54;
  localparam logic [5:0] RollFirst   = 6'd5;
  localparam logic [5:0] RollLast    = 6'd8;
  localparam logic [5:0] PitchFirst  = 6'd23;
  localparam logic [5:0] PitchLast   = 6'd26;
  localparam logic [5:0] YawFirst    = 6'd41;
  localparam logic [5:0] YawLast     = 6'd44;

  // Zoom frame
  localparam logic [7:0] ZoomHdr0    = 8'h90;
  localparam logic [7:0] ZoomHdr1    = 8'h50;
  localparam logic [7:0] ZoomTrailer = 8'hFF;
  localparam logic [2:0] NibbleCount = 3'd4;

  typedef enum logic [2:0] {
    ANGLE_IDLE    = 3'd0,
    ANGLE_H1      = 3'd1,
    ANGLE_H2      = 3'd2,
    ANGLE_H3      = 3'd3,
    ANGLE_PAYLOAD = 3'd4,
    ANGLE_CHECK   = 3'd5
  } angle_phase_e;

  typedef enum logic [1:0] {
    ZOOM_IDLE    = 2'd0,
    ZOOM_H1      = 2'd1,
    ZOOM_NIBBLES = 2'd2,
    ZOOM_TRAILER = 2'd3
  } zoom_phase_e;

  typedef struct packed {
    logic        angle_valid;
    logic [31:0] roll_raw;
    logic [31:0] pitch_raw;
    logic [31:0] yaw_raw;
    logic        zoom_valid;
    logic [15:0] zoom_value;
  } result_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] roll;
    logic [31:0] pitch;
    logic [31:0] yaw;
  } angle_res_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] value;
  } zoom_res_t;

endpackage

[src/gimbal_reply_frame_parser_core.sv]
// ----------------------------------------------------------------------------
// gimbal_reply_frame_parser_core
// Runs the angle and zoom frame recognizers on each received byte and
// reports completed frames.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------
//   in      | input     | in_valid_i / in_stall_o  | rx_byte_i
//   out     | output    | out_valid_o / out_stall_i| angle/roll/pitch/yaw/zoom
//
// One byte per cycle while in_stall_o is low; a completed frame's result is
// registered in the result register, or parked in the skid stage behind it.
// Reset clears both recognizers to idle and empties the result stage.
// in_stall_o rises only when a result is held by out_stall_i and a second
// one has been parked in the skid stage; it falls once the held word is taken.
// ----------------------------------------------------------------------------
module gimbal_reply_frame_parser_core
  import grfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        angle_valid_o,
  output logic [31:0] roll_raw_o,
  output logic [31:0] pitch_raw_o,
  output logic [31:0] yaw_raw_o,
  output logic        zoom_valid_o,
  output logic [15:0] zoom_value_o
);

  logic       accept;
  logic       full;
  angle_res_t angle_res;
  zoom_res_t  zoom_res;
  result_t    res;
  result_t    out_word;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  grfp_angle u_angle (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (accept),
    .byte_i       (rx_byte_i),
    .res_o        (angle_res)
  );

  grfp_zoom u_zoom (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (accept),
    .byte_i       (rx_byte_i),
    .res_o        (zoom_res)
  );

  always_comb begin
    res.angle_valid = angle_res.ok;
    res.roll_raw    = angle_res.roll;
    res.pitch_raw   = angle_res.pitch;
    res.yaw_raw     = angle_res.yaw;
    res.zoom_valid  = zoom_res.ok;
    res.zoom_value  = zoom_res.value;
  end

  grfp_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (angle_res.ok || zoom_res.ok),
    .res_i       (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_word)
  );

  assign angle_valid_o = out_word.angle_valid;
  assign roll_raw_o    = out_word.roll_raw;
  assign pitch_raw_o   = out_word.pitch_raw;
  assign yaw_raw_o     = out_word.yaw_raw;
  assign zoom_valid_o  = out_word.zoom_valid;
  assign zoom_value_o  = out_word.zoom_value;

endmodule

[src/grfp_angle.sv]
// ----------------------------------------------------------------------------
// grfp_angle
// Angle frame recognizer: header match, payload sum and word capture.
// ----------------------------------------------------------------------------
module grfp_angle
  import grfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic [7:0] byte_i,
  output angle_res_t res_o
);

  angle_phase_e phase_q, phase_d;
  logic [5:0]   count_q, count_d;
  logic [7:0]   sum_q, sum_d;
  logic [31:0]  roll_q, roll_d;
  logic [31:0]  pitch_q, pitch_d;
  logic [31:0]  yaw_q, yaw_d;
  logic         ok;
  logic [5:0]   count_inc;
  logic [5:0]   roll_off, pitch_off, yaw_off;

  assign count_inc = count_q + 6'd1;
  assign roll_off  = count_inc - RollFirst;
  assign pitch_off = count_inc - PitchFirst;
  assign yaw_off   = count_inc - YawFirst;

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    sum_d   = sum_q;
    roll_d  = roll_q;
    pitch_d = pitch_q;
    yaw_d   = yaw_q;
    ok      = 1'b0;
    if (byte_valid_i) begin
      unique case (phase_q)
        ANGLE_IDLE: begin
          if (byte_i == AngleHdr0) begin
            count_d = '0;
            sum_d   = '0;
            phase_d = ANGLE_H1;
          end
        end
        ANGLE_H1: phase_d = (byte_i == AngleHdr1) ? ANGLE_H2 : ANGLE_IDLE;
        ANGLE_H2: phase_d = (byte_i == AngleHdr2) ? ANGLE_H3 : ANGLE_IDLE;
        ANGLE_H3: phase_d = (byte_i == AngleHdr3) ? ANGLE_PAYLOAD : ANGLE_IDLE;
        ANGLE_PAYLOAD: begin
          count_d = count_inc;
          sum_d   = sum_q + byte_i;
          // drop the byte into its lane of the little-endian word
          if (count_inc >= RollFirst && count_inc <= RollLast) begin
            roll_d[roll_off[1:0]*8 +: 8] = byte_i;
          end else if (count_inc >= PitchFirst && count_inc <= PitchLast) begin
            pitch_d[pitch_off[1:0]*8 +: 8] = byte_i;
          end else if (count_inc >= YawFirst && count_inc <= YawLast) begin
            yaw_d[yaw_off[1:0]*8 +: 8] = byte_i;
          end
          if (count_inc == PayloadLen) begin
            phase_d = ANGLE_CHECK;
          end
        end
        ANGLE_CHECK: begin
          phase_d = ANGLE_IDLE;
          ok      = (sum_q == byte_i);
        end
        default: phase_d = ANGLE_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ANGLE_IDLE;
      count_q <= '0;
      sum_q   <= '0;
      roll_q  <= '0;
      pitch_q <= '0;
      yaw_q   <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      roll_q  <= roll_d;
      pitch_q <= pitch_d;
      yaw_q   <= yaw_d;
    end
  end

  // words are untouched on the checksum byte, so the held values go out
  assign res_o.ok    = ok;
  assign res_o.roll  = ok ? roll_q  : '0;
  assign res_o.pitch = ok ? pitch_q : '0;
  assign res_o.yaw   = ok ? yaw_q   : '0;

endmodule

[src/grfp_zoom.sv]
// ----------------------------------------------------------------------------
// grfp_zoom
// Zoom frame recognizer: header, four nibble bytes, trailing FF.
// ----------------------------------------------------------------------------
module grfp_zoom
  import grfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic [7:0] byte_i,
  output zoom_res_t  res_o
);

  zoom_phase_e phase_q, phase_d;
  logic [2:0]  count_q, count_d;
  logic [15:0] accum_q, accum_d;
  logic        ok;
  logic [2:0]  count_inc;

  assign count_inc = count_q + 3'd1;

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    accum_d = accum_q;
    ok      = 1'b0;
    if (byte_valid_i) begin
      unique case (phase_q)
        ZOOM_IDLE: begin
          if (byte_i == ZoomHdr0) begin
            count_d = '0;
            accum_d = '0;
            phase_d = ZOOM_H1;
          end
        end
        ZOOM_H1: phase_d = (byte_i == ZoomHdr1) ? ZOOM_NIBBLES : ZOOM_IDLE;
        ZOOM_NIBBLES: begin
          if (byte_i[7:4] == 4'h0) begin
            count_d = count_inc;
            accum_d = {accum_q[11:0], byte_i[3:0]};
            if (count_inc == NibbleCount) begin
              phase_d = ZOOM_TRAILER;
            end
          end else begin
            phase_d = ZOOM_IDLE;
          end
        end
        ZOOM_TRAILER: begin
          phase_d = ZOOM_IDLE;
          ok      = (byte_i == ZoomTrailer);
        end
        default: phase_d = ZOOM_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ZOOM_IDLE;
      count_q <= '0;
      accum_q <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      accum_q <= accum_d;
    end
  end

  assign res_o.ok    = ok;
  assign res_o.value = ok ? accum_q : '0;

endmodule

[src/grfp_outbuf.sv]
// ----------------------------------------------------------------------------
// grfp_outbuf
// Result register with a skid stage in front of the output channel.
// ----------------------------------------------------------------------------
module grfp_outbuf
  import grfp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    res_valid_i,
  input  result_t res_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_o
);

  logic    main_valid_q, main_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t main_q, main_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop = main_valid_q && !out_stall_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      // input is held off; drain the skid word into the main slot
      if (pop) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (res_valid_i) begin
      if (!main_valid_q || pop) begin
        main_d       = res_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = res_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      main_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_o       = main_q;

endmodule

[src/grfp_checker.sv]
// ----------------------------------------------------------------------------
// grfp_checker
// Port-level checks on the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        angle_valid_o,
  input logic [31:0] roll_raw_o,
  input logic [31:0] pitch_raw_o,
  input logic [31:0] yaw_raw_o,
  input logic        zoom_valid_o,
  input logic [15:0] zoom_value_o
);

  // a stalled result word stays valid, with its angle flag, roll word and zoom value held
  `GRFP_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(angle_valid_o) && $stable(roll_raw_o) && $stable(zoom_value_o), "stalled output word changed")

  // every result word reports at least one completed frame
  `GRFP_ASSERT(a_out_flag, clk_i, rst_ni, out_valid_o |-> angle_valid_o || zoom_valid_o, "result word without a frame flag")

  // angle words are zero unless an angle frame completed
  `GRFP_ASSERT(a_angle_zero, clk_i, rst_ni, out_valid_o && !angle_valid_o |-> roll_raw_o == 32'd0 && pitch_raw_o == 32'd0 && yaw_raw_o == 32'd0, "angle words nonzero without angle frame")

  // zoom value is zero unless a zoom frame completed
  `GRFP_ASSERT(a_zoom_zero, clk_i, rst_ni, out_valid_o && !zoom_valid_o |-> zoom_value_o == 16'd0, "zoom value nonzero without zoom frame")

  // input backpressure only follows a held output word
  `GRFP_ASSERT(a_stall_cause, clk_i, rst_ni, $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i), "input stalled without output backpressure")

endmodule

bind gimbal_reply_frame_parser_core grfp_checker u_grfp_checker (.*);

[test/tb_gimbal_reply_frame_parser_core.sv]
// ----------------------------------------------------------------------------
// tb_gimbal_reply_frame_parser_core
// Feeds byte streams of angle frames, zoom frames, broken frames and noise
// into the parser under random idling and backpressure. A local copy of both
// recognizers predicts every report, and the output is checked in order.
// ----------------------------------------------------------------------------
module tb_gimbal_reply_frame_parser_core;
  import grfp_pkg::*;

  localparam int PlBytes    = int'(PayloadLen);
  localparam int HoldCycles = 200;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        angle_valid_o;
  logic [31:0] roll_raw_o;
  logic [31:0] pitch_raw_o;
  logic [31:0] yaw_raw_o;
  logic        zoom_valid_o;
  logic [15:0] zoom_value_o;

  gimbal_reply_frame_parser_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .angle_valid_o(angle_valid_o),
    .roll_raw_o   (roll_raw_o),
    .pitch_raw_o  (pitch_raw_o),
    .yaw_raw_o    (yaw_raw_o),
    .zoom_valid_o (zoom_valid_o),
    .zoom_value_o (zoom_value_o)
  );

  // Shadow recognizer state
  angle_phase_e angle_ph;
  logic [5:0]   pay_cnt;
  logic [7:0]   pay_sum;
  logic [31:0]  roll_w;
  logic [31:0]  pitch_w;
  logic [31:0]  yaw_w;
  zoom_phase_e  zoom_ph;
  logic [2:0]   nib_cnt;
  logic [15:0]  zoom_acc;

  result_t     frame_reports_q[$];
  logic [7:0]  frame_pl [PlBytes];
  int          n_errors;
  int          bytes_sent;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          hold_reqs;
  int          hold_taken;
  int          hold_left;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Update both recognizers with one byte and queue the report it causes.
  task automatic track_byte(input logic [7:0] b);
    logic    angle_done;
    logic    zoom_done;
    int      lane;
    result_t r;
    angle_done = 1'b0;
    zoom_done  = 1'b0;
    case (angle_ph)
      ANGLE_IDLE: begin
        if (b == AngleHdr0) begin
          pay_cnt  = '0;
          pay_sum  = '0;
          angle_ph = ANGLE_H1;
        end
      end
      ANGLE_H1: angle_ph = (b == AngleHdr1) ? ANGLE_H2 : ANGLE_IDLE;
      ANGLE_H2: angle_ph = (b == AngleHdr2) ? ANGLE_H3 : ANGLE_IDLE;
      ANGLE_H3: angle_ph = (b == AngleHdr3) ? ANGLE_PAYLOAD : ANGLE_IDLE;
      ANGLE_PAYLOAD: begin
        pay_cnt = pay_cnt + 6'd1;
        pay_sum = pay_sum + b;
        if (pay_cnt >= RollFirst && pay_cnt <= RollLast) begin
          lane = int'(pay_cnt) - int'(RollFirst);
          roll_w[8*lane +: 8] = b;
        end else if (pay_cnt >= PitchFirst && pay_cnt <= PitchLast) begin
          lane = int'(pay_cnt) - int'(PitchFirst);
          pitch_w[8*lane +: 8] = b;
        end else if (pay_cnt >= YawFirst && pay_cnt <= YawLast) begin
          lane = int'(pay_cnt) - int'(YawFirst);
          yaw_w[8*lane +: 8] = b;
        end
        if (pay_cnt == PayloadLen) angle_ph = ANGLE_CHECK;
      end
      ANGLE_CHECK: begin
        angle_done = (pay_sum == b);
        angle_ph   = ANGLE_IDLE;
      end
      default: angle_ph = ANGLE_IDLE;
    endcase
    case (zoom_ph)
      ZOOM_IDLE: begin
        if (b == ZoomHdr0) begin
          nib_cnt  = '0;
          zoom_acc = '0;
          zoom_ph  = ZOOM_H1;
        end
      end
      ZOOM_H1: zoom_ph = (b == ZoomHdr1) ? ZOOM_NIBBLES : ZOOM_IDLE;
      ZOOM_NIBBLES: begin
        if (b[7:4] == 4'h0) begin
          nib_cnt  = nib_cnt + 3'd1;
          zoom_acc = {zoom_acc[11:0], b[3:0]};
          if (nib_cnt == NibbleCount) zoom_ph = ZOOM_TRAILER;
        end else begin
          zoom_ph = ZOOM_IDLE;
        end
      end
      default: begin
        zoom_done = (b == ZoomTrailer);
        zoom_ph   = ZOOM_IDLE;
      end
    endcase
    if (angle_done || zoom_done) begin
      r.angle_valid = angle_done;
      r.roll_raw    = angle_done ? roll_w : '0;
      r.pitch_raw   = angle_done ? pitch_w : '0;
      r.yaw_raw     = angle_done ? yaw_w : '0;
      r.zoom_valid  = zoom_done;
      r.zoom_value  = zoom_done ? zoom_acc : '0;
      frame_reports_q.push_back(r);
    end
  endtask

  // Offer one byte, with a random gap first, and hold it until taken.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < tx_idle_pct) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    track_byte(b);
    bytes_sent++;
  endtask

  // Drop valid and wait until every expected report has come out.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (frame_reports_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_angle_header();
    send_byte(AngleHdr0);
    send_byte(AngleHdr1);
    send_byte(AngleHdr2);
    send_byte(AngleHdr3);
  endtask

  // Send frame_pl as an angle frame; corrupt the checksum on request.
  task automatic send_angle(input bit bad_sum);
    logic [7:0] sum;
    sum = '0;
    send_angle_header();
    for (int i = 0; i < PlBytes; i++) begin
      sum = sum + frame_pl[i];
      send_byte(frame_pl[i]);
    end
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    send_byte(sum);
  endtask

  task automatic fill_payload();
    int pick;
    pick = $urandom_range(9);
    for (int i = 0; i < PlBytes; i++) begin
      if (pick == 0) frame_pl[i] = 8'hFF;
      else if (pick == 1) frame_pl[i] = 8'h00;
      else frame_pl[i] = 8'($urandom_range(255));
    end
  endtask

  task automatic send_zoom(input logic [15:0] val);
    send_byte(ZoomHdr0);
    send_byte(ZoomHdr1);
    for (int i = 3; i >= 0; i--) send_byte({4'h0, val[4*i +: 4]});
    send_byte(ZoomTrailer);
  endtask

  // Send a zoom frame cut off by one wrong byte at a random spot.
  task automatic send_zoom_broken();
    logic [7:0] z [7];
    int pos;
    z[0] = ZoomHdr0;
    z[1] = ZoomHdr1;
    for (int i = 2; i < 6; i++) z[i] = 8'($urandom_range(15));
    z[6] = ZoomTrailer;
    pos = $urandom_range(1, 6);
    if (pos == 1) begin
      do z[1] = 8'($urandom_range(255)); while (z[1] == ZoomHdr1);
    end else if (pos == 6) begin
      do z[6] = 8'($urandom_range(255)); while (z[6] == ZoomTrailer);
    end else begin
      z[pos] = {4'($urandom_range(1, 15)), 4'($urandom_range(15))};
    end
    for (int i = 0; i <= pos; i++) send_byte(z[i]);
  endtask

  task automatic send_noise();
    logic [7:0] marks [8];
    marks = '{AngleHdr0, AngleHdr1, AngleHdr2, AngleHdr3,
              ZoomHdr0, ZoomHdr1, ZoomTrailer, 8'h0F};
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(1)) send_byte(marks[$urandom_range(7)]);
      else send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic test_zoom_frames();
    send_zoom(16'h0000);
    send_zoom(16'hFFFF);
    send_zoom(16'hA5C3);
    // a nibble byte with the high nibble set aborts, next frame still counts
    send_byte(ZoomHdr0);
    send_byte(ZoomHdr1);
    send_byte(8'h01);
    send_byte(8'h10);
    send_zoom(16'h1234);
    // wrong trailer byte
    send_byte(ZoomHdr0);
    send_byte(ZoomHdr1);
    for (int i = 1; i <= 4; i++) send_byte(8'(i));
    send_byte(8'h00);
  endtask

  task automatic test_angle_frames();
    for (int i = 0; i < PlBytes; i++) frame_pl[i] = 8'hFF;
    send_angle(1'b0);
    for (int i = 0; i < PlBytes; i++) frame_pl[i] = 8'h00;
    send_angle(1'b0);
    for (int i = 0; i < PlBytes; i++) frame_pl[i] = 8'($urandom_range(255));
    send_angle(1'b0);
  endtask

  task automatic test_special_cases();
    logic [7:0] rest;
    // repeated start byte is consumed, not taken as a new start
    send_byte(AngleHdr0);
    fill_payload();
    send_angle(1'b0);
    send_byte(ZoomHdr0);
    send_zoom(16'h0F0F);
    // bad checksum gives nothing; the next good frame overwrites the words
    fill_payload();
    send_angle(1'b1);
    fill_payload();
    send_angle(1'b0);
    // angle checksum FF doubles as the zoom trailer
    for (int i = 0; i < PlBytes; i++) frame_pl[i] = 8'($urandom_range(255));
    frame_pl[PlBytes-8] = 8'hAA;
    frame_pl[PlBytes-7] = 8'hAA;
    frame_pl[PlBytes-6] = ZoomHdr0;
    frame_pl[PlBytes-5] = ZoomHdr1;
    frame_pl[PlBytes-4] = 8'h0A;
    frame_pl[PlBytes-3] = 8'h0B;
    frame_pl[PlBytes-2] = 8'h0C;
    frame_pl[PlBytes-1] = 8'h0D;
    rest = '0;
    for (int i = 1; i < PlBytes; i++) rest = rest + frame_pl[i];
    frame_pl[0] = 8'hFF - rest;
    send_angle(1'b0);
  endtask

  task automatic test_random(input int n_bytes);
    int stop_at;
    int pick;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        if ($urandom_range(9) == 0) begin
          // broken header
          pick = $urandom_range(1, 3);
          send_byte(AngleHdr0);
          if (pick > 1) send_byte(AngleHdr1);
          if (pick > 2) send_byte(AngleHdr2);
          send_byte(8'h00);
        end else begin
          fill_payload();
          send_angle($urandom_range(99) < 15);
        end
      end else if (pick < 75) begin
        if ($urandom_range(99) < 85) send_zoom(16'($urandom_range(16'hFFFF)));
        else send_zoom_broken();
      end else begin
        send_noise();
      end
    end
  endtask

  // Hold the output off while zoom frames keep coming, so the input stalls.
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_reqs++;
    repeat (12) send_zoom(16'($urandom_range(16'hFFFF)));
    wait_drained();
  endtask

  // Receiver stall: random, or a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_left == 0 && hold_taken != hold_reqs) begin
      hold_left  = HoldCycles;
      hold_taken = hold_reqs;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frame_reports_q.size() == 0) begin
        $error("report with no frame pending");
        n_errors++;
      end else begin
        exp_r = frame_reports_q.pop_front();
        check_field("angle_valid", 32'(exp_r.angle_valid), 32'(angle_valid_o));
        check_field("roll_raw", exp_r.roll_raw, roll_raw_o);
        check_field("pitch_raw", exp_r.pitch_raw, pitch_raw_o);
        check_field("yaw_raw", exp_r.yaw_raw, yaw_raw_o);
        check_field("zoom_valid", 32'(exp_r.zoom_valid), 32'(zoom_valid_o));
        check_field("zoom_value", 32'(exp_r.zoom_value), 32'(zoom_value_o));
      end
    end
  end

  initial begin
    #2000000;
    $display("[gimbal_reply_frame_parser_core] ERROR");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    rx_byte_i   = '0;
    out_stall_i = 1'b0;
    n_errors    = 0;
    bytes_sent  = 0;
    hold_reqs   = 0;
    hold_taken  = 0;
    hold_left   = 0;
    tx_idle_pct = 36;
    rx_idle_pct = 70;
    angle_ph    = ANGLE_IDLE;
    pay_cnt     = '0;
    pay_sum     = '0;
    roll_w      = '0;
    pitch_w     = '0;
    yaw_w       = '0;
    zoom_ph     = ZOOM_IDLE;
    nib_cnt     = '0;
    zoom_acc    = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_zoom_frames();
    test_angle_frames();
    test_special_cases();
    test_random(550);
    wait_drained();

    tx_idle_pct = 70;
    rx_idle_pct = 36;
    test_random(550);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random(450);
    test_backpressure();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (n_errors == 0 && frame_reports_q.size() == 0) begin
      $display("[gimbal_reply_frame_parser_core] OK");
    end else begin
      $display("[gimbal_reply_frame_parser_core] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/grfp_pkg.sv
src/grfp_angle.sv
src/grfp_zoom.sv
src/grfp_outbuf.sv
src/gimbal_reply_frame_parser_core.sv
src/grfp_checker.sv
test/tb_gimbal_reply_frame_parser_core.sv
